/* design/fdd_pkg.sv */
package fdd_pkg;

   // Default sizing of the previous-frame store and of the position counters
   localparam int unsigned PAIR_STORE_DEPTH_DEF = 524288;
   localparam int unsigned COORD_BITS_DEF       = 12;

   // Fixed field widths
   localparam int unsigned PIXEL_W     = 32;
   localparam int unsigned DIM_W       = 13;
   localparam int unsigned SHIFT_W     = 5;
   localparam int unsigned WPL_W       = 12;
   localparam int unsigned RECT_LO_W   = 12;
   localparam int unsigned RECT_HI_W   = 13;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 13;

   // Result word layout, lowest bit first
   localparam int unsigned RSP_LEFT_LSB   = PIXEL_W;
   localparam int unsigned RSP_TOP_LSB    = RSP_LEFT_LSB + RECT_LO_W;
   localparam int unsigned RSP_RIGHT_LSB  = RSP_TOP_LSB + RECT_LO_W;
   localparam int unsigned RSP_BOTTOM_LSB = RSP_RIGHT_LSB + RECT_HI_W;
   localparam int unsigned RSP_FIELDS_W   = RSP_BOTTOM_LSB + RECT_HI_W;
   localparam int unsigned RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_USER_W     = 2;
   localparam int unsigned USER_CHANGED   = 0;
   localparam int unsigned USER_DIRTY     = 1;

   // Geometry limits and register reset values
   localparam logic [DIM_W-1:0]   WIDTH_RESET       = 13'd1024;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET      = 13'd1024;
   localparam logic [DIM_W-1:0]   MAX_DIM           = 13'd4096;
   localparam logic [DIM_W-1:0]   MIN_WIDTH         = 13'd2;
   localparam logic [DIM_W-1:0]   MIN_HEIGHT        = 13'd1;
   localparam logic [SHIFT_W-1:0] RED_SHIFT_RESET   = 5'd11;
   localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RESET = 5'd6;
   localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RESET  = 5'd0;

   localparam logic [PIXEL_W-1:0] COLOR_MASK = 32'h001f001f;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_RED_SHIFT,
      CSR_GREEN_SHIFT,
      CSR_BLUE_SHIFT
   } csr_index_type;

   // Repack both pixels of a word into the remote 5:5:5 layout
   function automatic logic [PIXEL_W-1:0] to_remote(
      input logic [PIXEL_W-1:0] pixel,
      input logic [SHIFT_W-1:0] red,
      input logic [SHIFT_W-1:0] green,
      input logic [SHIFT_W-1:0] blue
   );
      logic [PIXEL_W-1:0] r;
      logic [PIXEL_W-1:0] g;
      logic [PIXEL_W-1:0] b;
      r = (pixel >> red) & COLOR_MASK;
      g = (pixel >> green) & COLOR_MASK;
      b = (pixel >> blue) & COLOR_MASK;
      return r | (g << 5) | (b << 10);
   endfunction

endpackage

/* design/frame_diff_dirty_rect_core.sv */
// Framebuffer change detector. Words of two 16-bit pixels arrive in raster order on req_ and
// are compared with the word kept from the previous frame at the same place; a changed word is
// stored and returned repacked to 5:5:5 with the per-color right shifts from the csr_ registers,
// and the bounding box of changed positions grows. Every word gives one result; on the last word
// of a frame (rsp_tlast) the result carries the dirty flag and the rectangle (left, top,
// right + 2, bottom + 1), and the box starts over. After reset a clearing pass zeroes the
// store, one word per cycle across every address, and req_tready stays low until it is
// done; csr_ writes are taken at any time. Then one word is accepted per cycle unless
// rsp_tready holds results back, limited by the store's one read and one write per cycle with a
// forward path for back-to-back words at the same address. Stages: address fold (with
// COORD_BITS + 14 - clog2(depth) more for a non-power-of-two depth), compare, result.
module frame_diff_dirty_rect_core import fdd_pkg::*; #(
   parameter int unsigned PAIR_STORE_DEPTH = PAIR_STORE_DEPTH_DEF,
   parameter int unsigned COORD_BITS       = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // pixel_pair
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // remote_pair, rect_left, rect_top, rect_right, rect_bottom, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,   // frame_end
   output logic [RSP_USER_W-1:0]  rsp_tuser,   // changed, any_dirty
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned CW     = COORD_BITS;
   localparam int unsigned AW     = (PAIR_STORE_DEPTH > 1) ? $clog2(PAIR_STORE_DEPTH) : 1;
   localparam int unsigned FULL_W = CW + WPL_W + 1;
   localparam int unsigned CMP_W  = ((CW > DIM_W) ? CW : DIM_W) + 1;
   localparam int unsigned PW     = PIXEL_W + 2 * CW + 1;

   // Configuration registers
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [SHIFT_W-1:0] red_shift_ff;
   logic [SHIFT_W-1:0] green_shift_ff;
   logic [SHIFT_W-1:0] blue_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= WIDTH_RESET;
         height_ff      <= HEIGHT_RESET;
         red_shift_ff   <= RED_SHIFT_RESET;
         green_shift_ff <= GREEN_SHIFT_RESET;
         blue_shift_ff  <= BLUE_SHIFT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_ff       <= csr_data;
            CSR_FRAME_HEIGHT: height_ff      <= csr_data;
            CSR_RED_SHIFT:    red_shift_ff   <= csr_data[SHIFT_W-1:0];
            CSR_GREEN_SHIFT:  green_shift_ff <= csr_data[SHIFT_W-1:0];
            CSR_BLUE_SHIFT:   blue_shift_ff  <= csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Clamp geometry
   logic [DIM_W-1:0] geo_width;
   logic [DIM_W-1:0] geo_height;
   logic [DIM_W-1:0] width_round;
   logic [WPL_W-1:0] words_per_line;

   always_comb begin
      geo_width  = width_ff;
      geo_height = height_ff;
      if (width_ff < MIN_WIDTH) begin
         geo_width = MIN_WIDTH;
      end else if (width_ff > MAX_DIM) begin
         geo_width = MAX_DIM;
      end
      if (height_ff < MIN_HEIGHT) begin
         geo_height = MIN_HEIGHT;
      end else if (height_ff > MAX_DIM) begin
         geo_height = MAX_DIM;
      end
   end

   assign width_round    = (geo_width + DIM_W'(1)) >> 1;
   assign words_per_line = width_round[WPL_W-1:0];

   // Raster position of the next word
   logic              clr_active_ff;
   logic [AW-1:0]     clr_addr_ff;
   logic              fold_in_ready;
   logic              req_accept;
   logic [CW-1:0]     column_ff;
   logic [CW-1:0]     column_in;
   logic [CW-1:0]     line_ff;
   logic [CW-1:0]     line_in;
   logic              line_end;
   logic              frame_end;
   logic [FULL_W-1:0] full_addr;

   assign req_tready = fold_in_ready && !clr_active_ff;
   assign req_accept = req_tvalid && req_tready;

   assign line_end  = (CMP_W'(column_ff) + CMP_W'(2)) >= CMP_W'(geo_width);
   assign frame_end = line_end && ((CMP_W'(line_ff) + CMP_W'(1)) >= CMP_W'(geo_height));
   assign full_addr = FULL_W'(line_ff) * FULL_W'(words_per_line) + FULL_W'(column_ff >> 1);

   always_comb begin
      column_in = column_ff;
      line_in   = line_ff;
      if (req_accept) begin
         priority if (frame_end) begin
            column_in = '0;
            line_in   = '0;
         end else if (line_end) begin
            column_in = '0;
            line_in   = line_ff + CW'(1);
         end else begin
            column_in = column_ff + CW'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         line_ff   <= '0;
      end else begin
         column_ff <= column_in;
         line_ff   <= line_in;
      end
   end

   // Fold the address into the store
   logic          fold_out_valid;
   logic          fold_out_ready;
   logic [AW-1:0] fold_addr;
   logic [PW-1:0] fold_payload;

   fdd_addr_fold #(
      .DEPTH (PAIR_STORE_DEPTH),
      .IN_W  (FULL_W),
      .AW    (AW),
      .PW    (PW)
   ) u_fold (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid && !clr_active_ff),
      .in_ready    (fold_in_ready),
      .in_addr     (full_addr),
      .in_payload  ({frame_end, line_ff, column_ff, req_tdata}),
      .out_valid   (fold_out_valid),
      .out_ready   (fold_out_ready),
      .out_addr    (fold_addr),
      .out_payload (fold_payload)
   );

   // Compare stage: store read data lines up with the word here
   logic               c_valid_ff;
   logic [PIXEL_W-1:0] c_pixel_ff;
   logic [CW-1:0]      c_column_ff;
   logic [CW-1:0]      c_line_ff;
   logic               c_last_ff;
   logic [AW-1:0]      c_addr_ff;
   logic               c_hit_ff;
   logic [PIXEL_W-1:0] c_fwd_ff;
   logic               o_valid_ff;
   logic               o_ready;
   logic               c_move;
   logic               c_load;
   logic [PIXEL_W-1:0] ram_rd_data;
   logic [PIXEL_W-1:0] prev_word;
   logic               word_changed;

   assign o_ready        = !o_valid_ff || rsp_tready;
   assign c_move         = c_valid_ff && o_ready;
   assign fold_out_ready = !c_valid_ff || c_move;
   assign c_load         = fold_out_valid && fold_out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (fold_out_ready) begin
         c_valid_ff <= fold_out_valid;
      end
   end

   // The leaving word is written in the same cycle the next one reads: forward it
   always_ff @(posedge clock) begin
      if (c_load) begin
         c_pixel_ff  <= fold_payload[PIXEL_W-1:0];
         c_column_ff <= fold_payload[PIXEL_W +: CW];
         c_line_ff   <= fold_payload[PIXEL_W + CW +: CW];
         c_last_ff   <= fold_payload[PW-1];
         c_addr_ff   <= fold_addr;
         c_hit_ff    <= c_move && (c_addr_ff == fold_addr);
         c_fwd_ff    <= c_pixel_ff;
      end
   end

   assign prev_word    = c_hit_ff ? c_fwd_ff : ram_rd_data;
   assign word_changed = c_valid_ff && (prev_word != c_pixel_ff);

   // Clear the store after reset, one word per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == AW'(PAIR_STORE_DEPTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   fdd_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (PAIR_STORE_DEPTH),
      .AW    (AW)
   ) u_prev_frame (
      .clock   (clock),
      .wr_en   (clr_active_ff || (c_move && word_changed)),
      .wr_addr (clr_active_ff ? clr_addr_ff : c_addr_ff),
      .wr_data (clr_active_ff ? '0 : c_pixel_ff),
      .rd_en   (c_load),
      .rd_addr (fold_addr),
      .rd_data (ram_rd_data)
   );

   // Bounding box of changed positions
   logic [CW-1:0] min_column_ff;
   logic [CW-1:0] max_column_ff;
   logic [CW-1:0] min_line_ff;
   logic [CW-1:0] max_line_ff;
   logic          seen_ff;
   logic [CW-1:0] min_column_upd;
   logic [CW-1:0] max_column_upd;
   logic [CW-1:0] min_line_upd;
   logic [CW-1:0] max_line_upd;
   logic          seen_upd;

   always_comb begin
      min_column_upd = min_column_ff;
      max_column_upd = max_column_ff;
      min_line_upd   = min_line_ff;
      max_line_upd   = max_line_ff;
      seen_upd       = seen_ff || word_changed;
      if (word_changed) begin
         if (c_column_ff < min_column_ff) min_column_upd = c_column_ff;
         if (c_column_ff > max_column_ff) max_column_upd = c_column_ff;
         if (c_line_ff < min_line_ff)     min_line_upd   = c_line_ff;
         if (c_line_ff > max_line_ff)     max_line_upd   = c_line_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_column_ff <= '1;
         max_column_ff <= '0;
         min_line_ff   <= '1;
         max_line_ff   <= '0;
         seen_ff       <= 1'b0;
      end else if (c_move) begin
         if (c_last_ff) begin
            min_column_ff <= '1;
            max_column_ff <= '0;
            min_line_ff   <= '1;
            max_line_ff   <= '0;
            seen_ff       <= 1'b0;
         end else begin
            min_column_ff <= min_column_upd;
            max_column_ff <= max_column_upd;
            min_line_ff   <= min_line_upd;
            max_line_ff   <= max_line_upd;
            seen_ff       <= seen_upd;
         end
      end
   end

   // Result word
   logic [PIXEL_W-1:0]   o_remote_in;
   logic                 o_dirty_in;
   logic [RECT_LO_W-1:0] o_left_in;
   logic [RECT_LO_W-1:0] o_top_in;
   logic [RECT_HI_W-1:0] o_right_in;
   logic [RECT_HI_W-1:0] o_bottom_in;
   logic [PIXEL_W-1:0]   o_remote_ff;
   logic                 o_changed_ff;
   logic                 o_last_ff;
   logic                 o_dirty_ff;
   logic [RECT_LO_W-1:0] o_left_ff;
   logic [RECT_LO_W-1:0] o_top_ff;
   logic [RECT_HI_W-1:0] o_right_ff;
   logic [RECT_HI_W-1:0] o_bottom_ff;

   always_comb begin
      o_remote_in = word_changed
                  ? to_remote(c_pixel_ff, red_shift_ff, green_shift_ff, blue_shift_ff)
                  : '0;
      o_dirty_in  = c_last_ff && seen_upd;
      o_left_in   = '0;
      o_top_in    = '0;
      o_right_in  = '0;
      o_bottom_in = '0;
      if (o_dirty_in) begin
         o_left_in   = RECT_LO_W'(min_column_upd);
         o_top_in    = RECT_LO_W'(min_line_upd);
         o_right_in  = RECT_HI_W'((CW + 1)'(max_column_upd) + (CW + 1)'(2));
         o_bottom_in = RECT_HI_W'((CW + 1)'(max_line_upd) + (CW + 1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_move) begin
         o_remote_ff  <= o_remote_in;
         o_changed_ff <= word_changed;
         o_last_ff    <= c_last_ff;
         o_dirty_ff   <= o_dirty_in;
         o_left_ff    <= o_left_in;
         o_top_ff     <= o_top_in;
         o_right_ff   <= o_right_in;
         o_bottom_ff  <= o_bottom_in;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELDS_W)'(0), o_bottom_ff, o_right_ff,
                        o_top_ff, o_left_ff, o_remote_ff};
   assign rsp_tuser  = {o_dirty_ff, o_changed_ff};

endmodule

/* design/fdd_ram.sv */
module fdd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 2,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; a read at the written address returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/fdd_addr_fold.sv */
module fdd_addr_fold #(
   parameter int unsigned DEPTH = 2,
   parameter int unsigned IN_W  = 8,
   parameter int unsigned AW    = 1,
   parameter int unsigned PW    = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [IN_W-1:0] in_addr,
   input  logic [PW-1:0]   in_payload,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [AW-1:0]   out_addr,
   output logic [PW-1:0]   out_payload
);

   // A power-of-two store needs only the low bits; otherwise fold the address
   // below DEPTH with one conditional subtract of DEPTH << k per stage.
   localparam bit          IS_POW2 = (DEPTH > 1) && ((DEPTH & (DEPTH - 1)) == 0);
   localparam int unsigned DB      = $clog2(DEPTH);
   localparam int unsigned FOLDS   = (IN_W + 1 > DB) ? IN_W + 1 - DB : 0;
   localparam int unsigned NS      = IS_POW2 ? 1 : FOLDS + 1;
   localparam int unsigned XW      = IN_W + 2;

   logic            valid_ff   [NS];
   logic [IN_W-1:0] addr_ff    [NS];
   logic [PW-1:0]   payload_ff [NS];
   logic            src_valid  [NS];
   logic [IN_W-1:0] src_addr   [NS];
   logic [PW-1:0]   src_payload[NS];
   logic            ready      [NS+1];

   // Stage feeds: raw input into the first stage, one fold step into each later one
   for (genvar s = 0; s < NS; s++) begin : g_stage
      if (s == 0) begin : g_head
         assign src_valid[s]   = in_valid;
         assign src_addr[s]    = in_addr;
         assign src_payload[s] = in_payload;
      end else begin : g_fold
         localparam logic [XW-1:0] SUB = XW'(DEPTH) << (NS - 1 - s);
         logic [XW-1:0] wide;
         assign wide           = XW'(addr_ff[s-1]);
         assign src_valid[s]   = valid_ff[s-1];
         assign src_addr[s]    = (wide >= SUB) ? IN_W'(wide - SUB) : addr_ff[s-1];
         assign src_payload[s] = payload_ff[s-1];
      end
      assign ready[s] = !valid_ff[s] || ready[s+1];
   end

   assign ready[NS] = out_ready;

   // Advance each stage whenever its successor makes room; bubbles collapse
   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            valid_ff[s] <= src_valid[s];
         end
         if (ready[s] && src_valid[s]) begin
            addr_ff[s]    <= src_addr[s];
            payload_ff[s] <= src_payload[s];
         end
      end
   end

   assign in_ready    = ready[0];
   assign out_valid   = valid_ff[NS-1];
   assign out_addr    = AW'(addr_ff[NS-1]);
   assign out_payload = payload_ff[NS-1];

endmodule

/* design/fdd_checker.sv */
module fdd_checker import fdd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic                   rsp_tlast,
   input logic [RSP_USER_W-1:0]  rsp_tuser
);

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // The store is being cleared right after reset, so no word is taken
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("input accepted before the store was cleared");

   // A dirty report only comes with the last word of a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_DIRTY] |-> rsp_tlast)
      else $error("dirty flag outside frame end");

   // Without a dirty report the rectangle reads as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[USER_DIRTY] |-> rsp_tdata[RSP_FIELDS_W-1:RSP_LEFT_LSB] == '0)
      else $error("rectangle set without dirty flag");

   // Unchanged words carry no pixels, and the 5:5:5 packing never sets bits 15 and 31
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[15] && !rsp_tdata[31]
                     && (rsp_tuser[USER_CHANGED] || rsp_tdata[PIXEL_W-1:0] == '0))
      else $error("bad remote word");

endmodule

bind frame_diff_dirty_rect_core fdd_checker u_fdd_checker (.*);
